// ===== hdl/scrl_lcd_pkg.sv =====
// ----------------------------------------------------------------------------
// scrl_lcd_pkg
// Shared types, register indexes and the LCD init sequence table.
// ----------------------------------------------------------------------------
package scrl_lcd_pkg;

  localparam logic [1:0] REG_ENABLED    = 2'd0;
  localparam logic [1:0] REG_WAIT_TICKS = 2'd1;
  localparam logic [1:0] REG_CHAR_TICKS = 2'd2;

  localparam logic [1:0] PH_INIT  = 2'd0;
  localparam logic [1:0] PH_IDLE  = 2'd1;
  localparam logic [1:0] PH_PRINT = 2'd2;
  localparam logic [1:0] PH_WAIT  = 2'd3;

  localparam logic [7:0] SPACE_CH   = 8'h20;
  localparam logic [7:0] CMD_ROW0   = 8'h80;
  localparam logic [7:0] CMD_ROW1   = 8'hC0;
  localparam logic [7:0] WAIT_RESET = 8'd30;
  localparam logic [3:0] CHAR_RESET = 4'd1;
  localparam logic [2:0] INIT_LAST  = 3'd7;

  typedef struct packed {
    logic        out_kind;
    logic        reg_select;
    logic [7:0]  value;
    logic        upper_only;
    logic [13:0] pause_before_us;
    logic        final_res;
  } res_t;

  function automatic res_t init_entry(logic [2:0] idx);
    res_t r;
    r = '0;
    case (idx)
      3'd0: begin r.value = 8'h30; r.upper_only = 1'b1; r.pause_before_us = 14'd15000; end
      3'd1: begin r.value = 8'h30; r.upper_only = 1'b1; r.pause_before_us = 14'd5000; end
      3'd2: begin r.value = 8'h30; r.upper_only = 1'b1; r.pause_before_us = 14'd100; end
      3'd3: begin r.value = 8'h20; r.upper_only = 1'b1; end
      3'd4: r.value = 8'h28;
      3'd5: r.value = 8'h0C;
      3'd6: r.value = 8'h01;
      default: begin r.value = 8'h06; r.pause_before_us = 14'd1640; end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/scrl_lcd_ifs.sv =====
// ----------------------------------------------------------------------------
// scrl_lcd interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface scrl_lcd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] character;
  logic       line_end;
  modport source (output valid, kind, character, line_end, input ready);
  modport sink   (input valid, kind, character, line_end, output ready);
endinterface

interface scrl_lcd_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic        reg_select;
  logic [7:0]  value;
  logic        upper_only;
  logic [13:0] pause_before_us;
  logic        final_res;
  modport source (output valid, out_kind, reg_select, value, upper_only, pause_before_us,
                  final_res, input ready);
  modport sink   (input valid, out_kind, reg_select, value, upper_only, pause_before_us,
                  final_res, output ready);
endinterface

// ===== hdl/scrolling_two_line_lcd_controller_unit.sv =====
// ----------------------------------------------------------------------------
// scrolling_two_line_lcd_controller_unit
// Two-line LCD controller: line FIFO and screen rows held in RAMs.
// ----------------------------------------------------------------------------
// Character item: taken in ST_IDLE; a line_end item pads and closes the line in ST_PAD unless the line is dropped.
// Taking a line: read, copy up, write bottom per column (ST_TRD, ST_TWT, ST_TWB).
// Full refresh tick: 2*ROW_CHARS+4 results; screen reads go through ST_REF, then ST_REFD.
// Init tick: 8 results; every tick that emits a result can be held by output stalls.
// Reset: async active low; screen valid bits cleared so rows read as spaces.
module scrolling_two_line_lcd_controller_unit #(
  parameter int ROW_CHARS  = 16,
  parameter int FIFO_LINES = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  scrl_lcd_in_if.sink          in_i,
  scrl_lcd_out_if.source       res_o
);
  localparam int SDEPTH = 2 * ROW_CHARS;
  localparam int FDEPTH = FIFO_LINES * ROW_CHARS;
  localparam int SA  = $clog2(SDEPTH);
  localparam int FA  = $clog2(FDEPTH);
  localparam int FW  = $clog2(ROW_CHARS + 1);
  localparam int IW  = $clog2(ROW_CHARS);
  localparam int TW  = (FIFO_LINES > 1) ? $clog2(FIFO_LINES) : 1;
  localparam int CW  = $clog2(FIFO_LINES + 1);
  localparam int QW  = $clog2(2 * ROW_CHARS + 4);

  localparam logic [3:0] ST_IDLE = 4'd0, ST_PAD = 4'd1, ST_INIT = 4'd2,
                         ST_TRD = 4'd3, ST_TWT = 4'd4, ST_TWB = 4'd5,
                         ST_REF = 4'd6, ST_REFD = 4'd7, ST_BOT = 4'd8,
                         ST_BOTD = 4'd9, ST_NOTE = 4'd10;

  logic [3:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       en_q, en_d;
  logic [7:0] wait_q, wait_d;
  logic [3:0] cht_q, cht_d;
  logic [TW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [FW-1:0] fill_q, fill_d, col_q, col_d;
  logic       drop_q, drop_d, ended_q, ended_d, started_q, started_d, second_q, second_d;
  logic [7:0] timer_q, timer_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [2:0] icnt_q, icnt_d;
  logic [QW-1:0] seq_q, seq_d;
  logic [SDEPTH-1:0] sv_q, sv_d;
  logic       rv_q;
  logic       ov_q;
  scrl_lcd_pkg::res_t res_q, emit_res;
  logic       emit;

  logic          s_we, s_re, f_we, f_re;
  logic [SA-1:0] s_waddr, s_raddr;
  logic [FA-1:0] f_waddr, f_raddr;
  logic [7:0]    s_wdata, f_wdata, s_rdata, f_rdata, s_char;

  logic       out_free, acc, drop_now, ch_zero;
  logic [7:0] tnext;

  scrl_lcd_ram #(.WIDTH(8), .DEPTH(SDEPTH)) u_scr (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata));
  scrl_lcd_ram #(.WIDTH(8), .DEPTH(FDEPTH)) u_fifo (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .re_i(f_re), .raddr_i(f_raddr), .rdata_o(f_rdata));

  assign out_free = !ov_q || res_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign acc = in_i.valid && in_i.ready;
  assign drop_now = drop_q || (fill_q == '0 && count_q >= CW'(FIFO_LINES));
  assign ch_zero = (in_i.character == 8'd0);
  assign tnext = (timer_q == 8'hFF) ? timer_q : timer_q + 8'd1;
  // entries never written since init read as spaces
  assign s_char = rv_q ? s_rdata : scrl_lcd_pkg::SPACE_CH;
  assign f_waddr = FA'(tail_q) * FA'(ROW_CHARS) + FA'(fill_q);
  assign f_raddr = FA'(head_q) * FA'(ROW_CHARS) + FA'(idx_q);

  always_comb begin
    state_d = state_q; phase_d = phase_q;
    en_d = en_q; wait_d = wait_q; cht_d = cht_q;
    head_d = head_q; tail_d = tail_q; count_d = count_q;
    fill_d = fill_q; col_d = col_q; drop_d = drop_q; ended_d = ended_q;
    started_d = started_q; second_d = second_q; timer_d = timer_q;
    idx_d = idx_q; icnt_d = icnt_q; seq_d = seq_q; sv_d = sv_q;
    s_we = 1'b0; s_re = 1'b0; f_we = 1'b0; f_re = 1'b0;
    s_waddr = '0; s_raddr = '0; s_wdata = f_rdata; f_wdata = scrl_lcd_pkg::SPACE_CH;
    emit = 1'b0; emit_res = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        scrl_lcd_pkg::REG_ENABLED:    en_d = cfg_data_i[0];
        scrl_lcd_pkg::REG_WAIT_TICKS: wait_d = cfg_data_i;
        scrl_lcd_pkg::REG_CHAR_TICKS: cht_d = cfg_data_i[3:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (acc && !in_i.kind) begin
          if (!drop_now && fill_q < FW'(ROW_CHARS)) begin
            f_we = 1'b1;
            f_wdata = (ended_q || ch_zero) ? scrl_lcd_pkg::SPACE_CH : in_i.character;
            fill_d = fill_q + FW'(1);
            ended_d = ended_q || ch_zero;
          end
          drop_d = drop_now;
          if (in_i.line_end) begin
            if (!drop_now) state_d = ST_PAD;
            else begin
              fill_d = '0; drop_d = 1'b0; ended_d = 1'b0;
            end
          end
        end else if (acc && en_q) begin
          case (phase_q)
            scrl_lcd_pkg::PH_INIT: begin
              icnt_d = '0; state_d = ST_INIT;
            end
            scrl_lcd_pkg::PH_PRINT: begin
              if (tnext < {4'd0, cht_q}) timer_d = tnext;
              else begin
                timer_d = '0;
                if (!started_q) begin
                  started_d = 1'b1; seq_d = '0; state_d = ST_REF;
                end else if (col_q < FW'(ROW_CHARS)) begin
                  state_d = ST_BOT;
                end else begin
                  started_d = 1'b0; col_d = '0;
                  if (second_q) begin
                    second_d = 1'b0; phase_d = scrl_lcd_pkg::PH_WAIT;
                  end else begin
                    second_d = 1'b1; phase_d = scrl_lcd_pkg::PH_IDLE;
                    if (count_q == '0) state_d = ST_NOTE;
                  end
                end
              end
            end
            scrl_lcd_pkg::PH_WAIT: begin
              timer_d = tnext;
              if (tnext >= wait_q) begin
                phase_d = scrl_lcd_pkg::PH_IDLE;
                if (count_q == '0) state_d = ST_NOTE;
              end
            end
            default: begin
              if (count_q != '0) begin
                idx_d = '0; state_d = ST_TRD;
              end
            end
          endcase
        end
      end
      ST_PAD: begin
        if (fill_q < FW'(ROW_CHARS)) begin
          f_we = 1'b1;
          fill_d = fill_q + FW'(1);
        end else begin
          tail_d = (tail_q == TW'(FIFO_LINES - 1)) ? '0 : tail_q + TW'(1);
          count_d = count_q + CW'(1);
          fill_d = '0; drop_d = 1'b0; ended_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_INIT: begin
        if (out_free) begin
          emit = 1'b1;
          emit_res = scrl_lcd_pkg::init_entry(icnt_q);
          emit_res.final_res = (icnt_q == scrl_lcd_pkg::INIT_LAST);
          icnt_d = icnt_q + 3'd1;
          if (icnt_q == scrl_lcd_pkg::INIT_LAST) begin
            sv_d = '0; phase_d = scrl_lcd_pkg::PH_IDLE; state_d = ST_IDLE;
          end
        end
      end
      ST_TRD: begin
        s_re = 1'b1; f_re = 1'b1;
        s_raddr = SA'(ROW_CHARS) + SA'(idx_q);
        state_d = ST_TWT;
      end
      ST_TWT: begin
        s_we = 1'b1; s_waddr = SA'(idx_q); s_wdata = s_char;
        sv_d[SA'(idx_q)] = 1'b1;
        state_d = ST_TWB;
      end
      ST_TWB: begin
        s_we = 1'b1; s_waddr = SA'(ROW_CHARS) + SA'(idx_q); s_wdata = f_rdata;
        sv_d[SA'(ROW_CHARS) + SA'(idx_q)] = 1'b1;
        if (idx_q == IW'(ROW_CHARS - 1)) begin
          head_d = (head_q == TW'(FIFO_LINES - 1)) ? '0 : head_q + TW'(1);
          count_d = count_q - CW'(1);
          timer_d = '0; phase_d = scrl_lcd_pkg::PH_PRINT;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IW'(1); state_d = ST_TRD;
        end
      end
      ST_REF: begin
        // seq: row0 cmd, top chars, row1 cmd, blanks, row1 cmd, first bottom char
        if (seq_q >= QW'(1) && seq_q <= QW'(ROW_CHARS)) begin
          s_re = 1'b1; s_raddr = SA'(seq_q - QW'(1)); state_d = ST_REFD;
        end else if (seq_q == QW'(2 * ROW_CHARS + 3)) begin
          s_re = 1'b1; s_raddr = SA'(ROW_CHARS); state_d = ST_REFD;
        end else if (out_free) begin
          emit = 1'b1;
          if (seq_q == '0) emit_res.value = scrl_lcd_pkg::CMD_ROW0;
          else if (seq_q == QW'(ROW_CHARS + 1) || seq_q == QW'(2 * ROW_CHARS + 2))
            emit_res.value = scrl_lcd_pkg::CMD_ROW1;
          else begin
            emit_res.reg_select = 1'b1; emit_res.value = scrl_lcd_pkg::SPACE_CH;
          end
          seq_d = seq_q + QW'(1);
        end
      end
      ST_REFD: begin
        if (out_free) begin
          emit = 1'b1;
          emit_res.reg_select = 1'b1; emit_res.value = s_char;
          if (seq_q == QW'(2 * ROW_CHARS + 3)) begin
            emit_res.final_res = 1'b1; col_d = FW'(1); state_d = ST_IDLE;
          end else begin
            seq_d = seq_q + QW'(1); state_d = ST_REF;
          end
        end
      end
      ST_BOT: begin
        s_re = 1'b1; s_raddr = SA'(ROW_CHARS) + SA'(col_q); state_d = ST_BOTD;
      end
      ST_BOTD: begin
        if (out_free) begin
          emit = 1'b1;
          emit_res.reg_select = 1'b1; emit_res.value = s_char; emit_res.final_res = 1'b1;
          col_d = col_q + FW'(1); state_d = ST_IDLE;
        end
      end
      ST_NOTE: begin
        if (out_free) begin
          emit = 1'b1;
          emit_res.out_kind = 1'b1; emit_res.final_res = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; phase_q <= scrl_lcd_pkg::PH_INIT;
      en_q <= 1'b0; wait_q <= scrl_lcd_pkg::WAIT_RESET; cht_q <= scrl_lcd_pkg::CHAR_RESET;
      head_q <= '0; tail_q <= '0; count_q <= '0; fill_q <= '0; col_q <= '0;
      drop_q <= 1'b0; ended_q <= 1'b0; started_q <= 1'b0; second_q <= 1'b0;
      timer_q <= '0; idx_q <= '0; icnt_q <= '0; seq_q <= '0; sv_q <= '0;
      rv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d;
      en_q <= en_d; wait_q <= wait_d; cht_q <= cht_d;
      head_q <= head_d; tail_q <= tail_d; count_q <= count_d; fill_q <= fill_d;
      col_q <= col_d; drop_q <= drop_d; ended_q <= ended_d; started_q <= started_d;
      second_q <= second_d; timer_q <= timer_d; idx_q <= idx_d; icnt_q <= icnt_d;
      seq_q <= seq_d; sv_q <= sv_d;
      if (s_re) rv_q <= sv_q[s_raddr];
      if (emit) ov_q <= 1'b1;
      else if (res_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= emit_res;
  end

  assign res_o.valid           = ov_q;
  assign res_o.out_kind        = res_q.out_kind;
  assign res_o.reg_select      = res_q.reg_select;
  assign res_o.value           = res_q.value;
  assign res_o.upper_only      = res_q.upper_only;
  assign res_o.pause_before_us = res_q.pause_before_us;
  assign res_o.final_res       = res_q.final_res;

`ifndef SYNTH
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FIFO_LINES)) else $error("line count overflow");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(ROW_CHARS)) else $error("fill index overflow");
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_res.final_res) |=> (state_q == ST_IDLE)) else $error("final not at end");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result overwritten");
`endif
endmodule

// ===== hdl/scrl_lcd_ram.sv =====
// ----------------------------------------------------------------------------
// scrl_lcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scrl_lcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
